@@ rtl/tsbf_pkg.sv @@
// tsbf_pkg: shared types and codes for the two-stack back/forward history unit.
// No dependencies; used by the top level, tsbf_ctrl and tsbf_datapath in rtl/.
package tsbf_pkg;

	// operation codes of the command beat
	localparam logic [1:0] OP_VISIT   = 2'd0;
	localparam logic [1:0] OP_BACK    = 2'd1;
	localparam logic [1:0] OP_FORWARD = 2'd2;

	// register map (byte addresses)
	localparam int unsigned ADDR_BITS = 3;
	localparam logic [ADDR_BITS-1:0] REG_HOME_PAGE = 3'd0;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] page_id;
	} cmd_item_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] current_page;
	} res_item_t;

	// controller -> datapath
	typedef struct packed {
		logic visit;     // push current to back, take new page, clear forward
		logic move_back; // push current to forward, start pop of back
		logic move_fwd;  // push current to back, start pop of forward
		logic refuse;    // load result with ok = 0, nothing changes
		logic pop_done;  // popped page becomes current, load result
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic back_empty;
		logic fwd_empty;
	} dp_status_t;

endpackage

@@ rtl/two_stack_back_forward_history_unit.sv @@
// Top level of the two-stack back/forward history unit: APB register, controller, datapath.
// Depends on tsbf_pkg, tsbf_ctrl, tsbf_datapath (and tsbf_ram through it).
//
// Usage:
//   Command channel (cmd_valid / cmd_stall / cmd) carries one beat per operation:
//   visit (page_id becomes current), back or forward. Result channel
//   (res_valid / res_stall / res) returns exactly one beat per command: ok and
//   the current page after the operation.
//   Visit and refused operations: result registered at the accepting edge.
//   Back/forward that succeed read a stack store first (registered read), then
//   load the result in ST_POP once the result register is free. While in ST_POP
//   no command is taken; visits go one per cycle while results are drained.
//   A command is taken only when the result register is empty or being drained.
//   If the receiver stalls, the result beat holds and cmd_stall rises.
//   Reset clears counts, the current page and the home_page register (0); the
//   stack stores need no clearing, counts keep reads on written entries.
//   home_page sits at byte address 0; the user must write it only while idle, not enforced.
module two_stack_back_forward_history_unit #(
	parameter int unsigned HISTORY_DEPTH = 128,
	parameter int unsigned PAGE_ID_BITS  = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tsbf_pkg::ADDR_BITS-1:0]      paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	// command channel
	input  logic                                cmd_valid,
	output logic                                cmd_stall,
	input  tsbf_pkg::cmd_item_t                 cmd,
	// result channel
	output logic                                res_valid,
	input  logic                                res_stall,
	output tsbf_pkg::res_item_t                 res
);

	logic [31:0]          home_page_q;
	logic                 home_sel;
	tsbf_pkg::ctrl_cmd_t  ctl;
	tsbf_pkg::dp_status_t status;

	// word-aligned decode: byte lanes within the register all hit it
	assign home_sel = (paddr[tsbf_pkg::ADDR_BITS-1:2] ==
		tsbf_pkg::REG_HOME_PAGE[tsbf_pkg::ADDR_BITS-1:2]);
	assign pready   = 1'b1;
	assign prdata   = home_sel ? home_page_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			home_page_q <= 32'd0;
		end else if (psel && penable && pwrite && home_sel) begin
			home_page_q <= pwdata;
		end
	end

	tsbf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.operation(cmd.operation),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.status   (status),
		.ctl      (ctl)
	);

	tsbf_datapath #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.PAGE_ID_BITS (PAGE_ID_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.home_page(home_page_q),
		.page_id  (cmd.page_id),
		.ctl      (ctl),
		.status   (status),
		.res      (res)
	);

endmodule

@@ rtl/tsbf_ram.sv @@
// tsbf_ram: one stack store, single write port and registered read port.
// No package dependencies.
module tsbf_ram #(
	parameter int unsigned DEPTH = 128,
	parameter int unsigned WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

@@ rtl/tsbf_ctrl.sv @@
// tsbf_ctrl: sequencer for command beats, result valid and the pop wait state.
// Depends on tsbf_pkg.
module tsbf_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_stall,
	input  logic [1:0]             operation,
	output logic                   res_valid,
	input  logic                   res_stall,
	input  tsbf_pkg::dp_status_t   status,
	output tsbf_pkg::ctrl_cmd_t    ctl
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_POP  = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   res_valid_q;
	logic   res_free;
	logic   accept;
	logic   load_res;

	// result register can take a new beat this cycle
	assign res_free  = !res_valid_q || !res_stall;
	assign cmd_stall = !((state_q == ST_IDLE) && res_free);
	assign accept    = cmd_valid && !cmd_stall;
	assign res_valid = res_valid_q;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (operation)
						tsbf_pkg::OP_VISIT: begin
							ctl.visit = 1'b1;
						end
						tsbf_pkg::OP_BACK: begin
							if (status.back_empty) begin
								ctl.refuse = 1'b1;
							end else begin
								ctl.move_back = 1'b1;
								state_d       = ST_POP;
							end
						end
						tsbf_pkg::OP_FORWARD: begin
							if (status.fwd_empty) begin
								ctl.refuse = 1'b1;
							end else begin
								ctl.move_fwd = 1'b1;
								state_d      = ST_POP;
							end
						end
						default: begin
							ctl.refuse = 1'b1;
						end
					endcase
				end
			end
			ST_POP: begin
				if (res_free) begin
					ctl.pop_done = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign load_res = ctl.visit || ctl.refuse || ctl.pop_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/tsbf_datapath.sv @@
// tsbf_datapath: current page, stack counts, both stack stores and result payload.
// Depends on tsbf_pkg and tsbf_ram.
module tsbf_datapath #(
	parameter int unsigned HISTORY_DEPTH = 128,
	parameter int unsigned PAGE_ID_BITS  = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [31:0]            home_page,
	input  logic [31:0]            page_id,
	input  tsbf_pkg::ctrl_cmd_t    ctl,
	output tsbf_pkg::dp_status_t   status,
	output tsbf_pkg::res_item_t    res
);

	localparam int unsigned AW = $clog2(HISTORY_DEPTH);
	localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned PW = PAGE_ID_BITS;
	localparam logic [CW-1:0] FULL = CW'(HISTORY_DEPTH);

	logic [PW-1:0] present_q;
	logic          started_q;
	logic [CW-1:0] back_cnt_q, fwd_cnt_q;
	logic          pop_fwd_q;
	tsbf_pkg::res_item_t res_q;

	logic [PW+31:0] home_ext, page_ext, cur_ext, pop_ext, new_ext;
	logic [PW-1:0]  home_pg, new_pg, cur_pg, pop_pg;
	logic [CW-1:0]  back_base, fwd_base;
	logic [CW-1:0]  back_dec, fwd_dec;

	logic          back_we, fwd_we;
	logic [AW-1:0] back_waddr, fwd_waddr;
	logic [PW-1:0] back_rdata, fwd_rdata;

	// width changes between 32-bit ports and PW-bit pages
	assign home_ext = {{PW{1'b0}}, home_page};
	assign page_ext = {{PW{1'b0}}, page_id};
	assign home_pg  = home_ext[PW-1:0];
	assign new_pg   = page_ext[PW-1:0];
	assign cur_pg   = started_q ? present_q : home_pg;
	assign pop_pg   = pop_fwd_q ? fwd_rdata : back_rdata;
	assign cur_ext  = {32'd0, cur_pg};
	assign pop_ext  = {32'd0, pop_pg};
	assign new_ext  = {32'd0, new_pg};

	// a full target stack is emptied before the push
	assign back_base = (back_cnt_q == FULL) ? '0 : back_cnt_q;
	assign fwd_base  = (fwd_cnt_q == FULL) ? '0 : fwd_cnt_q;
	assign back_dec  = back_cnt_q - 1'b1;
	assign fwd_dec   = fwd_cnt_q - 1'b1;

	assign status.back_empty = (back_cnt_q == '0);
	assign status.fwd_empty  = (fwd_cnt_q == '0);

	// visit with a full back stack drops the old current page
	assign back_we    = (ctl.visit && (back_cnt_q != FULL)) || ctl.move_fwd;
	assign back_waddr = ctl.visit ? back_cnt_q[AW-1:0] : back_base[AW-1:0];
	assign fwd_we     = ctl.move_back;
	assign fwd_waddr  = fwd_base[AW-1:0];

	tsbf_ram #(
		.DEPTH(HISTORY_DEPTH),
		.WIDTH(PW)
	) u_back_ram (
		.clk    (clk),
		.we     (back_we),
		.waddr  (back_waddr),
		.wdata  (cur_pg),
		.re     (ctl.move_back),
		.raddr  (back_dec[AW-1:0]),
		.rdata_q(back_rdata)
	);

	tsbf_ram #(
		.DEPTH(HISTORY_DEPTH),
		.WIDTH(PW)
	) u_fwd_ram (
		.clk    (clk),
		.we     (fwd_we),
		.waddr  (fwd_waddr),
		.wdata  (cur_pg),
		.re     (ctl.move_fwd),
		.raddr  (fwd_dec[AW-1:0]),
		.rdata_q(fwd_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q  <= '0;
			started_q  <= 1'b0;
			back_cnt_q <= '0;
			fwd_cnt_q  <= '0;
			pop_fwd_q  <= 1'b0;
		end else begin
			if (ctl.visit) begin
				present_q <= new_pg;
				started_q <= 1'b1;
				fwd_cnt_q <= '0;
				if (back_cnt_q != FULL) begin
					back_cnt_q <= back_cnt_q + 1'b1;
				end
			end
			if (ctl.move_back) begin
				fwd_cnt_q  <= fwd_base + 1'b1;
				back_cnt_q <= back_dec;
				pop_fwd_q  <= 1'b0;
			end
			if (ctl.move_fwd) begin
				back_cnt_q <= back_base + 1'b1;
				fwd_cnt_q  <= fwd_dec;
				pop_fwd_q  <= 1'b1;
			end
			if (ctl.pop_done) begin
				present_q <= pop_pg;
				started_q <= 1'b1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (ctl.visit) begin
			res_q.ok           <= 1'b1;
			res_q.current_page <= new_ext[31:0];
		end else if (ctl.refuse) begin
			res_q.ok           <= 1'b0;
			res_q.current_page <= cur_ext[31:0];
		end else if (ctl.pop_done) begin
			res_q.ok           <= 1'b1;
			res_q.current_page <= pop_ext[31:0];
		end
	end

	assign res = res_q;

endmodule

@@ verif/tsbf_history_checker.sv @@
`timescale 1ns / 1ps
// Checker for the two-stack back/forward history unit: tracks the home page register,
// predicts every result beat from accepted commands and compares. Depends on tsbf_pkg.
module tsbf_history_checker #(
	parameter int unsigned HISTORY_DEPTH = 128
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [tsbf_pkg::ADDR_BITS-1:0]     paddr,
	input  logic [31:0]                        pwdata,
	input  logic                               pready,
	input  logic                               cmd_valid,
	input  logic                               cmd_stall,
	input  tsbf_pkg::cmd_item_t                cmd,
	input  logic                               res_valid,
	input  logic                               res_stall,
	input  tsbf_pkg::res_item_t                res,
	output int                                 mismatches,
	output int                                 pages_owed
);

	logic [31:0] home_reg;
	logic [31:0] present;
	logic        started;
	logic [31:0] back_pages [HISTORY_DEPTH];
	logic [31:0] fwd_pages  [HISTORY_DEPTH];
	int unsigned back_depth;
	int unsigned fwd_depth;
	tsbf_pkg::res_item_t predicted_pages [$];

	// step the history by one command, return the beat the block owes for it
	function automatic tsbf_pkg::res_item_t advance_history(tsbf_pkg::cmd_item_t c);
		tsbf_pkg::res_item_t r;
		logic [31:0] cur;
		cur = started ? present : home_reg;
		r.ok = 1'b0;
		case (c.operation)
			tsbf_pkg::OP_VISIT: begin
				if (back_depth < HISTORY_DEPTH) begin
					back_pages[back_depth] = cur;
					back_depth++;
				end
				present = c.page_id;
				started = 1'b1;
				fwd_depth = 0;
				r.ok = 1'b1;
			end
			tsbf_pkg::OP_BACK: begin
				if (back_depth != 0) begin
					if (fwd_depth >= HISTORY_DEPTH)
						fwd_depth = 0;
					fwd_pages[fwd_depth] = cur;
					fwd_depth++;
					back_depth--;
					present = back_pages[back_depth];
					started = 1'b1;
					r.ok = 1'b1;
				end
			end
			tsbf_pkg::OP_FORWARD: begin
				if (fwd_depth != 0) begin
					if (back_depth >= HISTORY_DEPTH)
						back_depth = 0;
					back_pages[back_depth] = cur;
					back_depth++;
					fwd_depth--;
					present = fwd_pages[fwd_depth];
					started = 1'b1;
					r.ok = 1'b1;
				end
			end
			default: ;
		endcase
		r.current_page = started ? present : home_reg;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int errs;
		tsbf_pkg::res_item_t want;
		errs = 0;
		if (!arst_n) begin
			home_reg = '0;
			present = '0;
			started = 1'b0;
			back_depth = 0;
			fwd_depth = 0;
			predicted_pages.delete();
			mismatches <= 0;
			pages_owed <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (predicted_pages.size() == 0) begin
					$display("%0t: result beat with none expected: ok=%0b page=%h",
						$time, res.ok, res.current_page);
					errs++;
				end else begin
					want = predicted_pages.pop_front();
					if (res.ok !== want.ok) begin
						$display("%0t: ok mismatch: expected %0b, actual %0b",
							$time, want.ok, res.ok);
						errs++;
					end
					if (res.current_page !== want.current_page) begin
						$display("%0t: current_page mismatch: expected %h, actual %h",
							$time, want.current_page, res.current_page);
						errs++;
					end
				end
			end
			if (cmd_valid && !cmd_stall)
				predicted_pages.push_back(advance_history(cmd));
			if (psel && penable && pwrite && pready && paddr == tsbf_pkg::REG_HOME_PAGE)
				home_reg = pwdata;
			mismatches <= mismatches + errs;
			pages_owed <= predicted_pages.size();
		end
	end

endmodule

@@ verif/tb_two_stack_back_forward_history_unit.sv @@
`timescale 1ns / 1ps
// Testbench top for the two-stack back/forward history unit: clock, reset, APB and
// command stimulus, receiver stalls, watchdog, verdict.
// Depends on tsbf_pkg, the unit, tsbf_history_checker.
module tb_two_stack_back_forward_history_unit;

	localparam int unsigned DEPTH       = 128;
	localparam logic [1:0]  OP_UNKNOWN  = 2'd3;  // undecoded code, block must refuse it
	localparam int          PHASE_BEATS = 660;   // three phases, ~2000 beats total
	localparam int          QUIET_LIMIT = 2000;  // cycles with no handshake before giving up

	logic                           clk;
	logic                           arst_n;
	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [tsbf_pkg::ADDR_BITS-1:0] paddr = '0;
	logic [31:0]                    pwdata = '0;
	logic [31:0]                    prdata;
	logic                           pready;
	logic                           cmd_valid = 1'b0;
	logic                           cmd_stall;
	tsbf_pkg::cmd_item_t            cmd = '0;
	logic                           res_valid;
	logic                           res_stall = 1'b0;
	tsbf_pkg::res_item_t            res;

	int mismatches;
	int pages_owed;
	int send_idle_pct;
	int recv_idle_pct;
	int quiet_cycles;

	two_stack_back_forward_history_unit #(
		.HISTORY_DEPTH(DEPTH),
		.PAGE_ID_BITS (32)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	tsbf_history_checker #(.HISTORY_DEPTH(DEPTH)) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.pready    (pready),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.mismatches(mismatches),
		.pages_owed(pages_owed)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver back-pressure, re-rolled every cycle at the falling edge
	always @(negedge clk) begin
		res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	// watchdog: any handshake on any port counts as progress
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall) ||
				(psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// mostly random ids, with the all-zero and all-one corners mixed in
	function automatic logic [31:0] pick_page();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll == 0)
			return 32'h0000_0000;
		if (roll == 1)
			return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	// one command beat; valid stays up across back-to-back beats
	task automatic send_cmd(logic [1:0] op, logic [31:0] page);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_valid = 1'b0;
			@(negedge clk);
		end
		cmd.operation = op;
		cmd.page_id = page;
		cmd_valid = 1'b1;
		do
			@(posedge clk);
		while (cmd_stall);
		@(negedge clk);
	endtask

	// park the command side until every owed result beat has come back
	task automatic drain_results();
		cmd_valid = 1'b0;
		while (pages_owed != 0)
			@(negedge clk);
	endtask

	// APB write: setup, then access; lands on the edge with pready high
	task automatic write_home(logic [31:0] value);
		drain_results();
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = tsbf_pkg::REG_HOME_PAGE;
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// random traffic: runs of visits and moves with random length, so the back stack fills
	// past its depth and both drain to empty; a slice of odd/undecoded beats as noise
	task automatic run_phase(int sidle, int ridle);
		int sent;
		int roll;
		int len;
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		sent = 0;
		while (sent < PHASE_BEATS) begin
			roll = $urandom_range(0, 99);
			if ($urandom_range(0, 49) == 0)
				drain_results();
			if (roll < 42) begin
				len = $urandom_range(1, 6);
				repeat (len) send_cmd(tsbf_pkg::OP_VISIT, pick_page());
			end else if (roll < 62) begin
				len = $urandom_range(1, 8);
				repeat (len) send_cmd(tsbf_pkg::OP_BACK, $urandom);
			end else if (roll < 78) begin
				len = $urandom_range(1, 8);
				repeat (len) send_cmd(tsbf_pkg::OP_FORWARD, $urandom);
			end else if (roll < 85) begin
				// overfill the back stack: drops the old current page once full
				len = $urandom_range(DEPTH - 8, DEPTH + 12);
				repeat (len) send_cmd(tsbf_pkg::OP_VISIT, pick_page());
			end else if (roll < 90) begin
				// walk all the way back (and past empty), then part way forward
				len = $urandom_range(DEPTH - 8, DEPTH + 8);
				repeat (len) send_cmd(tsbf_pkg::OP_BACK, $urandom);
				sent += len;
				len = $urandom_range(1, DEPTH + 4);
				repeat (len) send_cmd(tsbf_pkg::OP_FORWARD, $urandom);
			end else begin
				len = $urandom_range(1, 4);
				repeat (len) send_cmd(2'($urandom_range(0, 3)), $urandom);
			end
			sent += len;
		end
		drain_results();
	endtask

	initial begin
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: refused moves and undecoded beats show the home page until first success
		write_home(32'hFFFF_FFFF);
		send_cmd(tsbf_pkg::OP_BACK, 32'h0);
		send_cmd(tsbf_pkg::OP_FORWARD, 32'hFFFF_FFFF);
		send_cmd(OP_UNKNOWN, 32'h1234_5678);
		write_home(32'h0000_0000);
		send_cmd(tsbf_pkg::OP_BACK, 32'hFFFF_FFFF);
		send_cmd(OP_UNKNOWN, 32'hFFFF_FFFF);
		// first visit pushes home, then walk back past empty and forward past empty
		send_cmd(tsbf_pkg::OP_VISIT, 32'hFFFF_FFFF);
		send_cmd(tsbf_pkg::OP_VISIT, 32'h0000_0000);
		send_cmd(tsbf_pkg::OP_BACK, 32'h0);
		send_cmd(tsbf_pkg::OP_BACK, 32'h0);
		send_cmd(tsbf_pkg::OP_BACK, 32'h0);
		send_cmd(tsbf_pkg::OP_FORWARD, 32'h0);
		send_cmd(tsbf_pkg::OP_FORWARD, 32'h0);
		send_cmd(tsbf_pkg::OP_FORWARD, 32'h0);
		// visit in the middle of history drops the forward stack
		send_cmd(tsbf_pkg::OP_VISIT, 32'h5A5A_A5A5);
		send_cmd(tsbf_pkg::OP_BACK, 32'h0);
		send_cmd(tsbf_pkg::OP_VISIT, 32'hA5A5_5A5A);
		send_cmd(tsbf_pkg::OP_FORWARD, 32'h0);
		send_cmd(OP_UNKNOWN, 32'h0);
		send_cmd(tsbf_pkg::OP_BACK, 32'h0);

		// home page is irrelevant once started, but each phase still reprograms it
		write_home($urandom);
		run_phase(19, 49);
		write_home($urandom);
		run_phase(49, 19);
		write_home(32'h0000_0000);
		run_phase(0, 0);

		cmd_valid = 1'b0;
		drain_results();
		// linger to catch any stray result beat
		repeat (10) @(negedge clk);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
